@@ hdl/htfd_pkg.sv @@
package htfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned RAW_W = 20;
  localparam int unsigned PAYLOAD_W = 40;
  localparam int unsigned HUM_W = 14;
  localparam int unsigned TEMP_W = 15;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
  localparam int unsigned STATUS_BUSY_BIT = 7;
  localparam int unsigned STATUS_CAL_BIT = 3;
  localparam logic [IDX_W-1:0] IDX_STATUS = 3'd0;
  localparam logic [IDX_W-1:0] IDX_LAST_PAYLOAD = 3'd5;

  localparam logic [HUM_W-1:0] HUM_SCALE = 14'd10000;
  localparam logic [TEMP_W-1:0] TEMP_SCALE = 15'd20000;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;
  localparam logic [HUM_W-1:0] HUM_MAX = 14'd9999;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd5000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd14999;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_BUSY    = 2'd1,
    RC_CRC_ERR = 2'd2
  } result_code_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [HUM_W-1:0]         humidity_centi;
    logic [RAW_W-1:0]         temp_reading;
    logic [RAW_W-1:0]         hum_reading;
    logic                     calibrated;
    result_code_t             result_code;
  } result_t;

  // One CRC-8 byte step, MSB first, unrolled over the eight bits.
  function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/humidity_temp_frame_decoder_core.sv @@
// Sensor reply frame decoder.
// The input channel (in_*) takes one reply byte per item: the status byte,
// five payload bytes and a CRC byte. in_tuser high marks the status byte of a
// frame and restarts the byte count and the CRC, dropping a partial frame.
// After the seventh byte the next byte starts a new frame without a marker.
// The output channel (out_*) gives one item per complete frame: the result
// code (ok, busy, CRC mismatch), the calibration flag, both 20-bit raw
// readings and their values in hundredths. On busy or CRC mismatch the raw
// and scaled fields are zero.
// Throughput is one byte per cycle while in_tready is high. After the seventh
// byte is accepted, one register holds the checked frame and then the output
// register holds the scaled values behind the two constant multipliers.
// When the receiver stalls, the output register holds its item and one more
// frame result can wait in the first stage; in_tready drops only when both
// are full. Reset clears the byte count, the CRC and both valid flags.
module humidity_temp_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] result_code, [2] calibrated, [22:3] hum_reading,
  // [42:23] temp_reading, [56:43] humidity_centi, [71:57] temperature_centi
  output logic [71:0] out_tdata
);

  logic [htfd_pkg::IDX_W-1:0]     byte_index_r, byte_index_nxt;
  logic [htfd_pkg::BYTE_W-1:0]    crc_r, crc_nxt;
  logic [htfd_pkg::BYTE_W-1:0]    status_r, status_nxt;
  logic [htfd_pkg::PAYLOAD_W-1:0] payload_r, payload_nxt;

  logic                         s1_valid_r, s1_valid_nxt;
  htfd_pkg::result_code_t       s1_code_r, s1_code_nxt;
  logic                         s1_cal_r, s1_cal_nxt;
  logic [htfd_pkg::RAW_W-1:0]   s1_hraw_r, s1_hraw_nxt;
  logic [htfd_pkg::RAW_W-1:0]   s1_traw_r, s1_traw_nxt;

  logic              out_valid_r, out_valid_nxt;
  htfd_pkg::result_t out_res_r, out_res_nxt;

  logic                          in_fire;
  logic                          out_free;
  logic                          s1_free;
  logic [htfd_pkg::IDX_W-1:0]    idx_eff;
  logic [htfd_pkg::BYTE_W-1:0]   crc_eff;
  logic [htfd_pkg::BYTE_W-1:0]   crc_step;
  logic [htfd_pkg::RAW_W+htfd_pkg::HUM_W-1:0]  hum_prod;
  logic [htfd_pkg::RAW_W+htfd_pkg::TEMP_W-1:0] temp_prod;
  logic [htfd_pkg::TEMP_W-1:0]   temp_scaled;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || out_free;
  assign in_tready = s1_free;
  assign in_fire   = in_tvalid && in_tready;

  assign idx_eff  = in_tuser ? htfd_pkg::IDX_STATUS : byte_index_r;
  assign crc_eff  = in_tuser ? htfd_pkg::CRC_INIT : crc_r;
  assign crc_step = htfd_pkg::crc_byte(crc_eff, in_tdata);

  always_comb begin
    byte_index_nxt = byte_index_r;
    crc_nxt        = crc_r;
    status_nxt     = status_r;
    payload_nxt    = payload_r;
    s1_valid_nxt   = s1_valid_r && !out_free;
    s1_code_nxt    = s1_code_r;
    s1_cal_nxt     = s1_cal_r;
    s1_hraw_nxt    = s1_hraw_r;
    s1_traw_nxt    = s1_traw_r;
    if (in_fire) begin
      if (idx_eff == htfd_pkg::IDX_STATUS) begin
        status_nxt     = in_tdata;
        crc_nxt        = crc_step;
        byte_index_nxt = idx_eff + 3'd1;
      end else if (idx_eff <= htfd_pkg::IDX_LAST_PAYLOAD) begin
        payload_nxt    = {payload_r[htfd_pkg::PAYLOAD_W-htfd_pkg::BYTE_W-1:0], in_tdata};
        crc_nxt        = crc_step;
        byte_index_nxt = idx_eff + 3'd1;
      end else begin
        byte_index_nxt = htfd_pkg::IDX_STATUS;
        crc_nxt        = htfd_pkg::CRC_INIT;
        s1_valid_nxt   = 1'b1;
        s1_cal_nxt     = status_r[htfd_pkg::STATUS_CAL_BIT];
        if (status_r[htfd_pkg::STATUS_BUSY_BIT]) begin
          s1_code_nxt = htfd_pkg::RC_BUSY;
        end else if (crc_eff != in_tdata) begin
          s1_code_nxt = htfd_pkg::RC_CRC_ERR;
        end else begin
          s1_code_nxt = htfd_pkg::RC_OK;
        end
        if (s1_code_nxt == htfd_pkg::RC_OK) begin
          s1_hraw_nxt = payload_r[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W];
          s1_traw_nxt = payload_r[htfd_pkg::RAW_W-1:0];
        end else begin
          s1_hraw_nxt = '0;
          s1_traw_nxt = '0;
        end
      end
    end
  end

  // A failed frame carries zero raw values, so its scaled values come out as
  // zero too once the offset is bypassed.
  assign hum_prod    = s1_hraw_r * htfd_pkg::HUM_SCALE;
  assign temp_prod   = s1_traw_r * htfd_pkg::TEMP_SCALE;
  assign temp_scaled = temp_prod[htfd_pkg::RAW_W+htfd_pkg::TEMP_W-1:htfd_pkg::RAW_W];

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    if (s1_valid_r && out_free) begin
      out_valid_nxt                 = 1'b1;
      out_res_nxt.result_code       = s1_code_r;
      out_res_nxt.calibrated        = s1_cal_r;
      out_res_nxt.hum_reading       = s1_hraw_r;
      out_res_nxt.temp_reading      = s1_traw_r;
      out_res_nxt.humidity_centi    =
        hum_prod[htfd_pkg::RAW_W+htfd_pkg::HUM_W-1:htfd_pkg::RAW_W];
      if (s1_code_r == htfd_pkg::RC_OK) begin
        out_res_nxt.temperature_centi = signed'(temp_scaled - htfd_pkg::TEMP_OFFSET);
      end else begin
        out_res_nxt.temperature_centi = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= htfd_pkg::IDX_STATUS;
      crc_r        <= htfd_pkg::CRC_INIT;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      crc_r        <= crc_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    payload_r <= payload_nxt;
    s1_code_r <= s1_code_nxt;
    s1_cal_r  <= s1_cal_nxt;
    s1_hraw_r <= s1_hraw_nxt;
    s1_traw_r <= s1_traw_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

@@ hdl/htfd_checker.sv @@
module htfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  htfd_pkg::result_t res;
  assign res = out_tdata;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled output item changed or dropped.");

  a_code_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.result_code == htfd_pkg::RC_OK ||
                    res.result_code == htfd_pkg::RC_BUSY ||
                    res.result_code == htfd_pkg::RC_CRC_ERR))
    else $error("Output item carries an unknown result code.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.result_code != htfd_pkg::RC_OK |->
      res.hum_reading == '0 && res.temp_reading == '0 &&
      res.humidity_centi == '0 && res.temperature_centi == '0)
    else $error("Failed frame carries nonzero readings.");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.result_code == htfd_pkg::RC_OK |->
      res.humidity_centi <= htfd_pkg::HUM_MAX &&
      res.temperature_centi >= htfd_pkg::TEMP_MIN &&
      res.temperature_centi <= htfd_pkg::TEMP_MAX)
    else $error("Scaled reading out of range.");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("Input stalled while the output register is empty.");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/humidity_temp_frame_checker.sv @@
module humidity_temp_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  output int          mismatches,
  output int          awaiting,
  output int          bytes_seen,
  output int          ok_seen,
  output int          busy_seen,
  output int          crc_err_seen
);

  htfd_pkg::result_t decoded_q[$];

  logic [htfd_pkg::IDX_W-1:0]     frame_pos;
  logic [htfd_pkg::BYTE_W-1:0]    crc_run;
  logic [htfd_pkg::BYTE_W-1:0]    frame_status;
  logic [htfd_pkg::PAYLOAD_W-1:0] payload_bits;

  function automatic logic [htfd_pkg::BYTE_W-1:0] crc8_step(
    input logic [htfd_pkg::BYTE_W-1:0] acc,
    input logic [htfd_pkg::BYTE_W-1:0] d);
    logic [htfd_pkg::BYTE_W-1:0] r;
    r = acc ^ d;
    repeat (htfd_pkg::BYTE_W)
      r = r[htfd_pkg::BYTE_W-1] ? ((r << 1) ^ htfd_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

  task automatic take_byte(input logic [htfd_pkg::BYTE_W-1:0] b, input logic start);
    htfd_pkg::result_t          frame_res;
    logic [htfd_pkg::RAW_W-1:0] h;
    logic [htfd_pkg::RAW_W-1:0] t;
    if (start) begin
      frame_pos = htfd_pkg::IDX_STATUS;
      crc_run = htfd_pkg::CRC_INIT;
    end
    if (frame_pos == htfd_pkg::IDX_STATUS) begin
      frame_status = b;
      crc_run = crc8_step(crc_run, b);
      frame_pos = htfd_pkg::IDX_STATUS + 3'd1;
    end else if (frame_pos <= htfd_pkg::IDX_LAST_PAYLOAD) begin
      payload_bits = {payload_bits[htfd_pkg::PAYLOAD_W-htfd_pkg::BYTE_W-1:0], b};
      crc_run = crc8_step(crc_run, b);
      frame_pos = frame_pos + 3'd1;
    end else begin
      frame_res = '0;
      frame_res.calibrated = frame_status[htfd_pkg::STATUS_CAL_BIT];
      if (frame_status[htfd_pkg::STATUS_BUSY_BIT]) begin
        frame_res.result_code = htfd_pkg::RC_BUSY;
      end else if (crc_run != b) begin
        frame_res.result_code = htfd_pkg::RC_CRC_ERR;
      end else begin
        h = payload_bits[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W];
        t = payload_bits[htfd_pkg::RAW_W-1:0];
        frame_res.result_code = htfd_pkg::RC_OK;
        frame_res.hum_reading = h;
        frame_res.temp_reading = t;
        frame_res.humidity_centi =
          htfd_pkg::HUM_W'((64'(h) * htfd_pkg::HUM_SCALE) >> htfd_pkg::RAW_W);
        frame_res.temperature_centi =
          htfd_pkg::TEMP_W'(((64'(t) * htfd_pkg::TEMP_SCALE) >> htfd_pkg::RAW_W)
                            - htfd_pkg::TEMP_OFFSET);
      end
      decoded_q.push_back(frame_res);
      frame_pos = htfd_pkg::IDX_STATUS;
      crc_run = htfd_pkg::CRC_INIT;
    end
  endtask

  task automatic check_field(input string what, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    htfd_pkg::result_t got;
    htfd_pkg::result_t want;
    if (!rst_n) begin
      frame_pos = htfd_pkg::IDX_STATUS;
      crc_run = htfd_pkg::CRC_INIT;
      frame_status = '0;
      payload_bits = '0;
      decoded_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item, expected none, got %h", $time, out_tdata);
        end else begin
          want = decoded_q.pop_front();
          case (want.result_code)
            htfd_pkg::RC_OK:   ok_seen++;
            htfd_pkg::RC_BUSY: busy_seen++;
            default:           crc_err_seen++;
          endcase
          check_field("result_code", 64'(want.result_code), 64'(got.result_code));
          check_field("calibrated", 64'(want.calibrated), 64'(got.calibrated));
          check_field("hum_reading", 64'(want.hum_reading), 64'(got.hum_reading));
          check_field("temp_reading", 64'(want.temp_reading), 64'(got.temp_reading));
          check_field("humidity_centi", 64'(want.humidity_centi), 64'(got.humidity_centi));
          check_field("temperature_centi", 64'(want.temperature_centi),
                      64'(got.temperature_centi));
        end
      end
      if (in_tvalid && in_tready) begin
        take_byte(in_tdata, in_tuser);
        bytes_seen++;
      end
    end
    awaiting = decoded_q.size();
  end

endmodule

@@ tb/humidity_temp_frame_decoder_core_tb.sv @@
module humidity_temp_frame_decoder_core_tb;

  localparam int BYTE_TARGET = 1650;
  localparam int CALM_FROM = 1400;
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [71:0] out_tdata;

  int mismatches;
  int awaiting;
  int bytes_seen;
  int ok_seen;
  int busy_seen;
  int crc_err_seen;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit jitter = 1'b1;
  bit calm = 1'b0;
  bit aligned = 1'b1;

  humidity_temp_frame_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  humidity_temp_frame_checker frame_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .bytes_seen   (bytes_seen),
    .ok_seen      (ok_seen),
    .busy_seen    (busy_seen),
    .crc_err_seen (crc_err_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && jitter && !calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic start);
    if (jitter && !calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic start, input logic [7:0] status,
                            input logic [htfd_pkg::PAYLOAD_W-1:0] payload,
                            input bit bad_crc);
    logic [7:0] crc;
    logic [7:0] b;
    crc = htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, status);
    send_item(status, start);
    for (int i = 4; i >= 0; i--) begin
      b = payload[i*8 +: 8];
      crc = htfd_pkg::crc_byte(crc, b);
      send_item(b, 1'b0);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    send_item(crc, 1'b0);
    aligned = 1'b1;
  endtask

  initial begin
    logic [7:0]                     status;
    logic [htfd_pkg::PAYLOAD_W-1:0] payload;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(1'b1, 8'h08, '0, 1'b0);
    send_frame(1'b0, 8'h77, '1, 1'b0);
    send_item(8'h1C, 1'b1);
    send_frame(1'b1, 8'hFF, {8'($urandom), 32'($urandom)}, 1'b1);
    send_frame(1'b1, 8'h00, {8'($urandom), 32'($urandom)}, 1'b1);

    // Mostly well-formed frames with random content; the rest are broken runs.
    while (bytes_sent < BYTE_TARGET) begin
      calm = bytes_sent >= CALM_FROM;
      if ($urandom_range(0, 19) == 0) jitter = !jitter;
      if ($urandom_range(0, 9) < 8) begin
        status = 8'($urandom);
        if ($urandom_range(0, 7) != 0) status[htfd_pkg::STATUS_BUSY_BIT] = 1'b0;
        payload = {8'($urandom), 32'($urandom)};
        case ($urandom_range(0, 7))
          0: payload[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W] = '0;
          1: payload[htfd_pkg::PAYLOAD_W-1:htfd_pkg::RAW_W] = '1;
          2: payload[htfd_pkg::RAW_W-1:0] = '0;
          3: payload[htfd_pkg::RAW_W-1:0] = '1;
          default: ;
        endcase
        send_frame(aligned ? 1'($urandom_range(0, 1)) : 1'b1, status, payload,
                   $urandom_range(0, 6) == 0);
      end else begin
        repeat ($urandom_range(1, 6)) send_item(8'($urandom), $urandom_range(0, 3) == 0);
        aligned = 1'b0;
      end
    end
    in_tvalid <= 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d reply bytes, with restarts and broken frames among them.", bytes_seen);
    $display("Checked results: %0d ok, %0d busy, %0d CRC mismatch.",
             ok_seen, busy_seen, crc_err_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
